@@ src/ucer_pkg.sv @@
// Package: shared constants, types and descriptor tables for the ep0 responder.
`timescale 1ns / 1ps
`default_nettype none
package ucer_pkg;

    localparam int MAX_PACKET_DEF     = 64;
    localparam int RESPONSE_BYTES_DEF = 256;

    localparam logic [1:0] TT_SETUP = 2'd0;
    localparam logic [1:0] TT_IN    = 2'd1;
    localparam logic [1:0] TT_OUT   = 2'd2;

    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;

    localparam logic [7:0] DESC_DEVICE = 8'h01;
    localparam logic [7:0] DESC_CONFIG = 8'h02;
    localparam logic [7:0] DESC_STRING = 8'h03;
    localparam logic [7:0] DESC_REPORT = 8'h22;

    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_VENDOR   = 2'd2;

    // source selector for the response fill
    typedef enum logic [2:0] {
        SRC_DEVICE = 3'd0,
        SRC_CONFIG = 3'd1,
        SRC_LANG   = 3'd2,
        SRC_STRING = 3'd3,
        SRC_REPORT = 3'd4,
        SRC_STATUS = 3'd5
    } src_t;

    function automatic logic [7:0] dev_byte(input logic [5:0] i, input logic [7:0] mps);
        logic [7:0] b;
        unique case (i)
            6'd0: b = 8'h12; 6'd1: b = 8'h01; 6'd2: b = 8'h10; 6'd3: b = 8'h01;
            6'd4: b = 8'h00; 6'd5: b = 8'h00; 6'd6: b = 8'h00; 6'd7: b = mps;
            6'd8: b = 8'hc7; 6'd9: b = 8'h05; 6'd10: b = 8'h13; 6'd11: b = 8'h01;
            6'd12: b = 8'h01; 6'd13: b = 8'h00; 6'd14: b = 8'h01; 6'd15: b = 8'h02;
            6'd16: b = 8'h03; 6'd17: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cfg_byte(input logic [5:0] i);
        logic [7:0] b;
        unique case (i)
            6'd0: b = 8'h09; 6'd1: b = 8'h02; 6'd2: b = 8'h22; 6'd3: b = 8'h00;
            6'd4: b = 8'h01; 6'd5: b = 8'h01; 6'd6: b = 8'h00; 6'd7: b = 8'ha0;
            6'd8: b = 8'h32; 6'd9: b = 8'h09; 6'd10: b = 8'h04; 6'd11: b = 8'h00;
            6'd12: b = 8'h00; 6'd13: b = 8'h01; 6'd14: b = 8'h03; 6'd15: b = 8'h00;
            6'd16: b = 8'h00; 6'd17: b = 8'h00; 6'd18: b = 8'h09; 6'd19: b = 8'h21;
            6'd20: b = 8'h10; 6'd21: b = 8'h01; 6'd22: b = 8'h00; 6'd23: b = 8'h01;
            6'd24: b = 8'h22; 6'd25: b = 8'h32; 6'd26: b = 8'h00; 6'd27: b = 8'h07;
            6'd28: b = 8'h05; 6'd29: b = 8'h81; 6'd30: b = 8'h03; 6'd31: b = 8'h10;
            6'd32: b = 8'h00; 6'd33: b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] lang_byte(input logic [5:0] i);
        logic [7:0] b;
        unique case (i)
            6'd0: b = 8'h04; 6'd1: b = 8'h03; 6'd2: b = 8'h09; 6'd3: b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] str_char(input logic [1:0] s, input logic [3:0] c);
        logic [7:0] b;
        b = 8'h00;
        unique case (s)
            2'd1: begin
                unique case (c)
                    4'd0: b = 8'h42; 4'd1: b = 8'h61; 4'd2: b = 8'h73; 4'd3: b = 8'h65;
                    4'd4: b = 8'h32; 4'd5: b = 8'h44; 4'd6: b = 8'h65; 4'd7: b = 8'h73;
                    4'd8: b = 8'h69; 4'd9: b = 8'h67; 4'd10: b = 8'h6e; 4'd11: b = 8'h73;
                    4'd12: b = 8'h20; 4'd13: b = 8'h20;
                    default: b = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (c)
                    4'd0: b = 8'h42; 4'd1: b = 8'h32; 4'd2: b = 8'h44; 4'd3: b = 8'h20;
                    4'd4: b = 8'h48; 4'd5: b = 8'h49; 4'd6: b = 8'h44; 4'd7: b = 8'h20;
                    4'd8: b = 8'h44; 4'd9: b = 8'h65; 4'd10: b = 8'h76; 4'd11: b = 8'h69;
                    4'd12: b = 8'h63; 4'd13: b = 8'h65;
                    default: b = 8'h00;
                endcase
            end
            2'd3: begin
                unique case (c)
                    4'd0: b = 8'h4c; 4'd1: b = 8'h69; 4'd2: b = 8'h6d; 4'd3: b = 8'h69;
                    4'd4: b = 8'h74; 4'd5: b = 8'h65; 4'd6: b = 8'h64; 4'd7: b = 8'h45;
                    4'd8: b = 8'h64; 4'd9: b = 8'h69; 4'd10: b = 8'h74; 4'd11: b = 8'h69;
                    4'd12: b = 8'h6f; 4'd13: b = 8'h6e;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] report_byte(input logic [5:0] i);
        logic [7:0] b;
        unique case (i)
            6'd0: b = 8'h05; 6'd1: b = 8'h01; 6'd2: b = 8'h09; 6'd3: b = 8'h00;
            6'd4: b = 8'ha1; 6'd5: b = 8'h01; 6'd6: b = 8'h09; 6'd7: b = 8'h00;
            6'd8: b = 8'ha1; 6'd9: b = 8'h00; 6'd10: b = 8'h05; 6'd11: b = 8'h09;
            6'd12: b = 8'h19; 6'd13: b = 8'h01; 6'd14: b = 8'h29; 6'd15: b = 8'h03;
            6'd16: b = 8'h15; 6'd17: b = 8'h00; 6'd18: b = 8'h25; 6'd19: b = 8'h01;
            6'd20: b = 8'h95; 6'd21: b = 8'h03; 6'd22: b = 8'h75; 6'd23: b = 8'h01;
            6'd24: b = 8'h81; 6'd25: b = 8'h02; 6'd26: b = 8'h95; 6'd27: b = 8'h01;
            6'd28: b = 8'h75; 6'd29: b = 8'h05; 6'd30: b = 8'h81; 6'd31: b = 8'h01;
            6'd32: b = 8'h05; 6'd33: b = 8'h01; 6'd34: b = 8'h09; 6'd35: b = 8'h30;
            6'd36: b = 8'h09; 6'd37: b = 8'h31; 6'd38: b = 8'h15; 6'd39: b = 8'h81;
            6'd40: b = 8'h25; 6'd41: b = 8'h7f; 6'd42: b = 8'h75; 6'd43: b = 8'h08;
            6'd44: b = 8'h95; 6'd45: b = 8'h02; 6'd46: b = 8'h81; 6'd47: b = 8'h06;
            6'd48: b = 8'hc0; 6'd49: b = 8'hc0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ src/usb_control_endpoint_responder_core.sv @@
// Top level: endpoint-0 request decoder, response store and packet emitter.
`timescale 1ns / 1ps
`default_nettype none
// One beat in per completed ep0 transaction, with the transaction type on
// s_tuser. Out come the bytes of the next transmit packet, one beat each,
// tlast on the final one. m_tuser (byte_valid) is low on the lone beat of a
// zero-length packet. A SETUP first fills the response store one byte a cycle
// with the whole descriptor (up to 50 bytes) through a shared byte counter.
// The packet is then read out of the store: each beat takes a registered read,
// a load of the output register and an output state held until the sink takes
// the beat. An IN goes straight to readout. The input is not ready from
// acceptance until the last beat of the packet is taken.
// No clearing pass: the store is only read where just written.
module usb_control_endpoint_responder_core #(
    parameter int MAX_PACKET     = ucer_pkg::MAX_PACKET_DEF,
    parameter int RESPONSE_BYTES = ucer_pkg::RESPONSE_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // trans_type[1:0]
    input  wire logic [1:0]  s_tuser,
    // request_type[7:0], request[15:8], setup_value[31:16], setup_index[47:32],
    // setup_length[63:48]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_byte[7:0], packet_size[14:8], data_toggle[15], address_update[16],
    // new_address[23:17]
    output logic [23:0]      m_tdata,
    // byte_valid[0]
    output logic             m_tuser,
    output logic             m_tlast
);
    localparam int AW = $clog2(RESPONSE_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_RD   = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] vendor_reg;
    logic [8:0]  rem_cnt_reg, rem_off_reg;
    logic [6:0]  pend_addr_reg;
    logic        armed_reg;

    logic [7:0]  mem [RESPONSE_BYTES];
    logic [7:0]  rd_data_reg;

    ucer_pkg::src_t src_reg;
    logic [1:0]  str_sel_reg;
    logic [7:0]  st0_reg, st1_reg;
    logic [5:0]  fill_len_reg;   // bytes to fill
    logic [5:0]  ctr_reg;        // shared byte counter (fill and readout)
    logic [8:0]  pkt_start_reg;
    logic [6:0]  pkt_n_reg;
    logic        upd_reg;
    logic [6:0]  addr_reg;

    logic [7:0]  m_byte_reg;
    logic        m_valid_byte_reg, m_last_reg, m_tvalid_reg;

    wire [1:0]  f_tt    = s_tuser;
    wire [7:0]  f_rtype = s_tdata[7:0];
    wire [7:0]  f_req   = s_tdata[15:8];
    wire [15:0] f_value = s_tdata[31:16];
    wire [15:0] f_index = s_tdata[47:32];
    wire [15:0] f_len   = s_tdata[63:48];
    wire        accept  = s_tvalid && s_tready;
    wire        set_addr_ok = (f_req == ucer_pkg::REQ_SET_ADDRESS) && (f_value <= 16'd127) &&
                              (f_index == 16'd0) && (f_len == 16'd0);

    assign s_tready = (state_reg == ST_IDLE);

    // setup decode
    logic [5:0] dsize;
    ucer_pkg::src_t dsrc;
    logic [15:0] cut;
    logic [6:0] first_n;
    always_comb begin
        dsize = '0;
        dsrc  = ucer_pkg::SRC_STATUS;
        if (f_req == ucer_pkg::REQ_GET_STATUS) begin
            if (f_rtype[6:5] == ucer_pkg::KIND_STANDARD ||
                f_rtype[6:5] == ucer_pkg::KIND_VENDOR) dsize = 6'd2;
        end else if (f_req == ucer_pkg::REQ_GET_DESCRIPTOR) begin
            priority if (f_value[15:8] == ucer_pkg::DESC_DEVICE) begin
                dsize = 6'd18; dsrc = ucer_pkg::SRC_DEVICE;
            end else if (f_value[15:8] == ucer_pkg::DESC_CONFIG) begin
                dsize = 6'd34; dsrc = ucer_pkg::SRC_CONFIG;
            end else if (f_value[15:8] == ucer_pkg::DESC_REPORT) begin
                dsize = 6'd50; dsrc = ucer_pkg::SRC_REPORT;
            end else if (f_value[15:8] == ucer_pkg::DESC_STRING) begin
                if (f_value[3:0] == 4'd0) begin
                    dsize = 6'd4; dsrc = ucer_pkg::SRC_LANG;
                end else if (f_value[3:0] <= 4'd3) begin
                    dsize = 6'd30; dsrc = ucer_pkg::SRC_STRING;
                end
            end else begin
                dsize = '0;
            end
        end
        cut = ({10'd0, dsize} > f_len) ? f_len : {10'd0, dsize};
        first_n = (cut > 16'(MAX_PACKET)) ? 7'(MAX_PACKET) : cut[6:0];
    end

    // fill byte from the selected source
    logic [7:0] fill_byte;
    always_comb begin
        unique case (src_reg)
            ucer_pkg::SRC_DEVICE: fill_byte = ucer_pkg::dev_byte(ctr_reg, 8'(MAX_PACKET));
            ucer_pkg::SRC_CONFIG: fill_byte = ucer_pkg::cfg_byte(ctr_reg);
            ucer_pkg::SRC_LANG:   fill_byte = ucer_pkg::lang_byte(ctr_reg);
            ucer_pkg::SRC_REPORT: fill_byte = ucer_pkg::report_byte(ctr_reg);
            ucer_pkg::SRC_STRING: begin
                if (ctr_reg == 6'd0)      fill_byte = 8'd30;
                else if (ctr_reg == 6'd1) fill_byte = 8'h03;
                else if (ctr_reg[0])      fill_byte = 8'h00;
                else fill_byte = ucer_pkg::str_char(str_sel_reg, 4'(ctr_reg[5:1] - 5'd1));
            end
            ucer_pkg::SRC_STATUS: fill_byte = ctr_reg[0] ? st1_reg : st0_reg;
            default:              fill_byte = 8'h00;
        endcase
    end

    wire [8:0] rd_pos = pkt_start_reg + {3'd0, ctr_reg};
    wire last_byte = ({1'b0, ctr_reg} + 7'd1 == pkt_n_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILL) mem[AW'(ctr_reg)] <= fill_byte;
        rd_data_reg <= (rd_pos < 9'(RESPONSE_BYTES)) ? mem[rd_pos[AW-1:0]] : 8'h00;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) begin
                if (f_tt == ucer_pkg::TT_SETUP)
                    state_next = (dsize != 6'd0) ? ST_FILL : ST_OUT;
                else if (f_tt == ucer_pkg::TT_IN)
                    state_next = (rem_cnt_reg != 9'd0) ? ST_RD : ST_OUT;
                else if (f_tt == ucer_pkg::TT_OUT)
                    state_next = ST_OUT;
            end
            ST_FILL: if (ctr_reg + 6'd1 == fill_len_reg)
                state_next = (pkt_n_reg != 7'd0) ? ST_RD : ST_OUT;
            ST_RD:   state_next = ST_WAIT;
            ST_WAIT: state_next = ST_OUT;
            ST_OUT:  if (m_tvalid_reg && m_tready)
                state_next = (m_last_reg) ? ST_IDLE : ST_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vendor_reg    <= '0;
            rem_cnt_reg   <= '0;
            rem_off_reg   <= '0;
            pend_addr_reg <= '0;
            armed_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) vendor_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE: if (accept) begin
                    ctr_reg <= '0;
                    if (f_tt == ucer_pkg::TT_SETUP) begin
                        armed_reg <= set_addr_ok;
                        if (set_addr_ok) pend_addr_reg <= f_value[6:0];
                        src_reg      <= dsrc;
                        str_sel_reg  <= f_value[1:0];
                        st0_reg      <= (f_rtype[6:5] == ucer_pkg::KIND_VENDOR) ? vendor_reg[7:0]
                                      : {7'd0, f_rtype[4:0] == 5'd0};
                        st1_reg      <= (f_rtype[6:5] == ucer_pkg::KIND_VENDOR) ? vendor_reg[15:8]
                                      : 8'h00;
                        fill_len_reg <= dsize;
                        pkt_start_reg <= '0;
                        pkt_n_reg    <= first_n;
                        rem_cnt_reg  <= 9'(cut) - {2'd0, first_n};
                        rem_off_reg  <= {2'd0, first_n};
                        upd_reg      <= 1'b0;
                        addr_reg     <= '0;
                    end else if (f_tt == ucer_pkg::TT_IN) begin
                        logic [6:0] n;
                        n = (rem_cnt_reg > 9'(MAX_PACKET)) ? 7'(MAX_PACKET) : rem_cnt_reg[6:0];
                        armed_reg     <= 1'b0;
                        upd_reg       <= armed_reg;
                        addr_reg      <= armed_reg ? pend_addr_reg : 7'd0;
                        pkt_start_reg <= rem_off_reg;
                        pkt_n_reg     <= n;
                        rem_cnt_reg   <= rem_cnt_reg - {2'd0, n};
                        rem_off_reg   <= rem_off_reg + {2'd0, n};
                    end else begin
                        pkt_n_reg <= '0;
                        upd_reg   <= 1'b0;
                        addr_reg  <= '0;
                    end
                    if ((f_tt == ucer_pkg::TT_OUT) ||
                        (f_tt == ucer_pkg::TT_SETUP && dsize == 6'd0) ||
                        (f_tt == ucer_pkg::TT_IN && rem_cnt_reg == 9'd0)) begin
                        // empty packet straight out
                        m_byte_reg       <= 8'h00;
                        m_valid_byte_reg <= 1'b0;
                        m_last_reg       <= 1'b1;
                        m_tvalid_reg     <= 1'b1;
                    end
                end
                ST_FILL: begin
                    if (ctr_reg + 6'd1 == fill_len_reg) begin
                        ctr_reg <= '0;
                        if (pkt_n_reg == 7'd0) begin
                            m_byte_reg       <= 8'h00;
                            m_valid_byte_reg <= 1'b0;
                            m_last_reg       <= 1'b1;
                            m_tvalid_reg     <= 1'b1;
                        end
                    end else begin
                        ctr_reg <= ctr_reg + 6'd1;
                    end
                end
                ST_WAIT: begin
                    m_byte_reg       <= rd_data_reg;
                    m_valid_byte_reg <= 1'b1;
                    m_last_reg       <= last_byte;
                    m_tvalid_reg     <= 1'b1;
                end
                ST_OUT: if (m_tvalid_reg && m_tready) begin
                    m_tvalid_reg <= 1'b0;
                    ctr_reg      <= ctr_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_valid_byte_reg;
    assign m_tdata  = {addr_reg, upd_reg, 1'b1, pkt_n_reg, m_byte_reg};

endmodule
`default_nettype wire

@@ src/ucer_checker.sv @@
// Port checker for the ep0 responder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ucer_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("beat dropped under stall");
    a_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15])
        else $error("data toggle low");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[14:8] == 7'd0)
        else $error("empty packet malformed");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while beat pending");
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[14:8] != 7'd0)
        else $error("data beat with zero packet size");
endmodule

bind usb_control_endpoint_responder_core ucer_checker u_ucer_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
);
`default_nettype wire

@@ verif/usb_control_endpoint_responder_core_test.sv @@
// Testbench: ep0 responder driven by directed and random transactions, checked per beat.
`timescale 1ns / 1ps
module usb_control_endpoint_responder_core_test;

    localparam int MAXP = ucer_pkg::MAX_PACKET_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  tt;
        logic [7:0]  rtype;
        logic [7:0]  req;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
    } txn_t;

    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       last;
        logic [6:0] psize;
        logic       tog;
        logic       upd;
        logic [6:0] addr;
    } beat_t;

    // directed row: typed-in first beat checked where known
    typedef struct {
        txn_t       t;
        logic       has_exp;
        logic [7:0] exp_byte;
        logic [6:0] exp_size;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    usb_control_endpoint_responder_core u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor state
    logic [15:0] vendor_word;
    logic [7:0]  resp_store [0:255];
    int unsigned left_count, left_offset;
    logic [6:0]  armed_addr;
    logic        armed;

    beat_t       pending_beats[$];
    int          errors = 0;
    int          beats_seen = 0;
    int          idle_cycles = 0;
    int          n_setup = 0, n_in = 0, n_out = 0;
    bit          stim_done = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] table_byte(ucer_pkg::src_t src, int i, int which);
        case (src)
            ucer_pkg::SRC_DEVICE: return ucer_pkg::dev_byte(i[5:0], 8'(MAXP));
            ucer_pkg::SRC_CONFIG: return ucer_pkg::cfg_byte(i[5:0]);
            ucer_pkg::SRC_REPORT: return ucer_pkg::report_byte(i[5:0]);
            ucer_pkg::SRC_LANG:   return ucer_pkg::lang_byte(i[5:0]);
            default: begin
                if (i == 0) return 8'd30;
                if (i == 1) return 8'h03;
                if (i[0]) return 8'h00;
                return ucer_pkg::str_char(which[1:0], 4'((i - 2) / 2));
            end
        endcase
    endfunction

    function automatic int load_descriptor(logic [15:0] value);
        ucer_pkg::src_t src;
        int n;
        src = ucer_pkg::SRC_STATUS;
        n = 0;
        case (value[15:8])
            ucer_pkg::DESC_DEVICE: begin src = ucer_pkg::SRC_DEVICE; n = 18; end
            ucer_pkg::DESC_CONFIG: begin src = ucer_pkg::SRC_CONFIG; n = 34; end
            ucer_pkg::DESC_REPORT: begin src = ucer_pkg::SRC_REPORT; n = 50; end
            ucer_pkg::DESC_STRING: begin
                if (value[3:0] == 0) begin src = ucer_pkg::SRC_LANG; n = 4; end
                else if (value[3:0] <= 3) begin src = ucer_pkg::SRC_STRING; n = 30; end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) resp_store[i] = table_byte(src, i, value[3:0]);
        return n;
    endfunction

    function automatic void queue_packet(int start, int n, logic upd, logic [6:0] addr);
        beat_t b;
        b.tog = 1'b1;
        b.upd = upd;
        b.addr = upd ? addr : 7'd0;
        if (n == 0) begin
            b.data = 0; b.vld = 0; b.last = 1; b.psize = 0;
            pending_beats.push_back(b);
            return;
        end
        for (int i = 0; i < n; i++) begin
            b.data = (start + i < 256) ? resp_store[start + i] : 8'd0;
            b.vld = 1;
            b.last = (i == n - 1);
            b.psize = 7'(n);
            pending_beats.push_back(b);
        end
    endfunction

    function automatic void predict_transaction(txn_t t);
        int size, n;
        logic upd;
        logic [6:0] addr;
        case (t.tt)
            ucer_pkg::TT_SETUP: begin
                n_setup++;
                size = 0;
                armed = 0;
                left_count = 0;
                left_offset = 0;
                if (t.req == ucer_pkg::REQ_GET_STATUS) begin
                    if (t.rtype[6:5] == ucer_pkg::KIND_STANDARD) begin
                        resp_store[0] = (t.rtype[4:0] == 0) ? 8'd1 : 8'd0;
                        resp_store[1] = 0;
                        size = 2;
                    end else if (t.rtype[6:5] == ucer_pkg::KIND_VENDOR) begin
                        resp_store[0] = vendor_word[7:0];
                        resp_store[1] = vendor_word[15:8];
                        size = 2;
                    end
                end else if (t.req == ucer_pkg::REQ_GET_DESCRIPTOR) begin
                    size = load_descriptor(t.value);
                end else if (t.req == ucer_pkg::REQ_SET_ADDRESS) begin
                    if (t.value <= 127 && t.index == 0 && t.length == 0) begin
                        armed_addr = t.value[6:0];
                        armed = 1;
                    end
                end
                if (size > t.length) size = t.length;
                n = (size > MAXP) ? MAXP : size;
                left_count = size - n;
                left_offset = n;
                queue_packet(0, n, 0, 0);
            end
            ucer_pkg::TT_IN: begin
                n_in++;
                upd = armed;
                addr = armed_addr;
                armed = 0;
                n = (left_count > MAXP) ? MAXP : left_count;
                queue_packet(left_offset, n, upd, addr);
                left_count -= n;
                left_offset = (left_offset + n) & 9'h1ff;
            end
            ucer_pkg::TT_OUT: begin
                n_out++;
                queue_packet(0, 0, 0, 0);
            end
            default: ;
        endcase
    endfunction

    // result checker and watchdog
    always @(posedge aclk) begin
        beat_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired, %0d beats outstanding", $time,
                         pending_beats.size());
                $display("usb_control_endpoint_responder_core verification failed");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.data = m_tdata[7:0];   got.vld = m_tuser;
                got.psize = m_tdata[14:8]; got.tog = m_tdata[15];
                got.upd = m_tdata[16];     got.addr = m_tdata[23:17];
                got.last = m_tlast;
                beats_seen++;
                if (pending_beats.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, exp none, got %h", $time, got);
                end else begin
                    want = pending_beats.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display({"%0t: beat mismatch exp byte=%h vld=%b last=%b size=%0d",
                                  " tog=%b upd=%b addr=%0d"},
                                 $time, want.data, want.vld, want.last, want.psize, want.tog,
                                 want.upd, want.addr);
                        $display({"%0t:                got byte=%h vld=%b last=%b size=%0d",
                                  " tog=%b upd=%b addr=%0d"},
                                 $time, got.data, got.vld, got.last, got.psize, got.tog,
                                 got.upd, got.addr);
                    end
                end
            end
        end
    end

    // sink stalls
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (stim_done && $urandom_range(0, 3) != 0) m_tready = 1;
            else if ($urandom_range(0, 9) < 3) m_tready = 0;
            else if ($urandom_range(0, 40) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(10, 60)) @(negedge aclk);
            end else m_tready = 1;
        end
    end

    task automatic put_item(txn_t t);
        s_tuser = t.tt;
        s_tdata = {t.length, t.index, t.value, t.req, t.rtype};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_transaction(t);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge aclk);
        else if ($urandom_range(0, 25) == 0) repeat ($urandom_range(20, 80)) @(negedge aclk);
    endtask

    task automatic send(txn_t t);
        put_item(t);
        idle_gap();
    endtask

    task automatic drain_and_configure(logic [15:0] w);
        while (pending_beats.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_wdata = w;
        cfg_we = 1;
        @(negedge aclk);
        cfg_we = 0;
        vendor_word = w;
    endtask

    function automatic txn_t mk(logic [1:0] tt, logic [7:0] rt, logic [7:0] rq,
                                logic [15:0] v, logic [15:0] ix, logic [15:0] ln);
        txn_t t;
        t = '{tt, rt, rq, v, ix, ln};
        return t;
    endfunction

    function automatic txn_t random_txn();
        txn_t t;
        int pick;
        t = mk(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
        pick = $urandom_range(0, 19);
        if (pick == 0) t.tt = 2'd3;
        else if (pick < 9) begin
            // setups with known requests and random content
            t.tt = ucer_pkg::TT_SETUP;
            t.rtype = {1'b1, ($urandom_range(0, 1) ? ucer_pkg::KIND_VENDOR
                                                   : ucer_pkg::KIND_STANDARD),
                       5'($urandom_range(0, 2))};
            case ($urandom_range(0, 4))
                0: t.req = ucer_pkg::REQ_GET_STATUS;
                1: begin
                    t.req = ucer_pkg::REQ_SET_ADDRESS;
                    t.value = 16'($urandom_range(0, 140));
                    t.index = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
                    t.length = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd0;
                end
                default: begin
                    t.req = ucer_pkg::REQ_GET_DESCRIPTOR;
                    case ($urandom_range(0, 4))
                        0: t.value[15:8] = ucer_pkg::DESC_DEVICE;
                        1: t.value[15:8] = ucer_pkg::DESC_CONFIG;
                        2: t.value[15:8] = ucer_pkg::DESC_STRING;
                        3: t.value[15:8] = ucer_pkg::DESC_REPORT;
                        default: ;
                    endcase
                    if ($urandom_range(0, 1)) t.value[7:0] = 8'($urandom_range(0, 4));
                end
            endcase
            if ($urandom_range(0, 2) == 0) t.length = 16'($urandom_range(0, 80));
        end else if (pick < 16) t.tt = ucer_pkg::TT_IN;
        return t;
    endfunction

    row_t rows[$];

    initial begin
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = 0;
        vendor_word = 0;
        left_count = 0;
        left_offset = 0;
        armed = 0;
        armed_addr = 0;
        foreach (resp_store[i]) resp_store[i] = 0;
        aresetn = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        rows = '{
            '{mk(ucer_pkg::TT_IN, 0, 0, 0, 0, 0), 1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_STATUS, 0, 0, 16'hffff),
              1, 8'h01, 7'd2},
            '{mk(ucer_pkg::TT_SETUP, 8'h81, ucer_pkg::REQ_GET_STATUS, 0, 0, 2), 1, 8'h00, 7'd2},
            '{mk(ucer_pkg::TT_SETUP, 8'hc0, ucer_pkg::REQ_GET_STATUS, 0, 0, 2), 1, 8'hff, 7'd2},
            '{mk(ucer_pkg::TT_SETUP, 8'ha0, ucer_pkg::REQ_GET_STATUS, 0, 0, 2), 1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_SETUP, 8'he0, ucer_pkg::REQ_GET_STATUS, 0, 0, 2), 1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 0, 64),
              1, 8'h12, 7'd18},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0200, 0, 16'hffff),
              1, 8'h09, 7'd34},
            '{mk(ucer_pkg::TT_SETUP, 8'h81, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h2200, 0, 16'hffff),
              1, 8'h05, 7'd50},
            '{mk(ucer_pkg::TT_IN, 0, 0, 0, 0, 0), 0, 0, 0},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0300, 0, 255),
              1, 8'h04, 7'd4},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0301, 16'h0409, 255),
              1, 8'd30, 7'd30},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0302, 0, 7),
              1, 8'd30, 7'd7},
            '{mk(ucer_pkg::TT_IN, 0, 0, 0, 0, 0), 0, 0, 0},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0303, 0, 255),
              0, 0, 0},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0304, 0, 255),
              1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_SETUP, 8'h80, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0700, 0, 255),
              1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_SETUP, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff), 1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_SETUP, 8'h00, ucer_pkg::REQ_SET_ADDRESS, 127, 0, 0), 1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_OUT, 0, 0, 0, 0, 0), 1, 8'h00, 7'd0},
            '{mk(ucer_pkg::TT_IN, 0, 0, 0, 0, 0), 0, 0, 0},
            '{mk(ucer_pkg::TT_SETUP, 8'h00, ucer_pkg::REQ_SET_ADDRESS, 128, 0, 0), 0, 0, 0},
            '{mk(ucer_pkg::TT_IN, 0, 0, 0, 0, 0), 0, 0, 0},
            '{mk(ucer_pkg::TT_SETUP, 8'h00, ucer_pkg::REQ_SET_ADDRESS, 5, 1, 0), 0, 0, 0},
            '{mk(2'd3, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff), 0, 0, 0}
        };

        drain_and_configure(16'hffff);
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                // first beat of this row is the head of the queue right after acceptance
                while (pending_beats.size() != 0) @(negedge aclk);
                put_item(rows[i].t);
                if (pending_beats.size() == 0) begin
                    errors++;
                    $display("%0t: row %0d exp byte=%h size=%0d, predicted no beat",
                             $time, i, rows[i].exp_byte, rows[i].exp_size);
                end else if (pending_beats[0].data !== rows[i].exp_byte ||
                             pending_beats[0].psize !== rows[i].exp_size) begin
                    errors++;
                    $display("%0t: row %0d first beat exp byte=%h size=%0d, predicted %h/%0d",
                             $time, i, rows[i].exp_byte, rows[i].exp_size,
                             pending_beats[0].data, pending_beats[0].psize);
                end
                idle_gap();
            end else send(rows[i].t);
        end

        for (int phase = 0; phase < 3; phase++) begin
            drain_and_configure(phase == 0 ? 16'h0000 : 16'($urandom));
            for (int k = 0; k < 37; k++) send(random_txn());
        end

        stim_done = 1;
        while (pending_beats.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        $display("Covered %0d setups, %0d INs, %0d OUTs; %0d result beats checked.",
                 n_setup, n_in, n_out, beats_seen);
        if (errors == 0 && pending_beats.size() == 0)
            $display("usb_control_endpoint_responder_core verification clean");
        else
            $display("usb_control_endpoint_responder_core verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
src/ucer_pkg.sv
src/usb_control_endpoint_responder_core.sv
src/ucer_checker.sv
verif/usb_control_endpoint_responder_core_test.sv
